// File: hw/rtl/ugcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the uniform grid cell binning block
package ugcb_pkg;

	// grid and slot geometry
	localparam int MAX_CELLS_PER_AXIS = 8;
	localparam int SLOTS_PER_CELL     = 8;
	localparam int MAX_PARTICLES      = 1024;
	localparam int FRAC_BITS          = 16;

	// word field widths
	localparam int POS_W  = 24;
	localparam int ID_W   = $clog2(MAX_PARTICLES);
	localparam int AXIS_W = $clog2(MAX_CELLS_PER_AXIS);
	localparam int IDX_W  = 3 * AXIS_W;
	localparam int SLOT_W = $clog2(SLOTS_PER_CELL);
	localparam int CNT_W  = $clog2(SLOTS_PER_CELL + 1);
	localparam int IP_W   = POS_W - FRAC_BITS - 1;

	// configuration port
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;
	localparam logic [CFG_W-1:0]     CELLS_RESET = 4'd8;

	// count memory: two cells per row, one valid bit per row
	localparam int NUM_CELLS = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
	localparam int ROW_CELLS = 2;
	localparam int NUM_ROWS  = NUM_CELLS / ROW_CELLS;
	localparam int ROW_AW    = IDX_W - 1;
	localparam int ROW_DW    = ROW_CELLS * CNT_W;

	// slot list memory
	localparam int SLOT_DEPTH = NUM_CELLS * SLOTS_PER_CELL;
	localparam int SLOT_AW    = IDX_W + SLOT_W;

	// operation codes
	localparam logic OP_CLEAR  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_STORED        = 2'd0,
		ST_OUT_OF_DOMAIN = 2'd1,
		ST_CELL_FULL     = 2'd2,
		ST_CLEARED       = 2'd3
	} status_t;

endpackage
`default_nettype wire

// File: hw/rtl/ugcb_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// channel interfaces of the uniform grid cell binning block
interface ugcb_in_if import ugcb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [ID_W-1:0]         particle_id;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source (output valid, op, particle_id, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, op, particle_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface ugcb_out_if import ugcb_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [AXIS_W-1:0] cell_x;
	logic [AXIS_W-1:0] cell_y;
	logic [AXIS_W-1:0] cell_z;
	logic [IDX_W-1:0]  cell_index;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, status, cell_x, cell_y, cell_z, cell_index, slot,
		input ready);
	modport sink (input valid, status, cell_x, cell_y, cell_z, cell_index, slot,
		output ready);
endinterface

interface ugcb_cfg_if import ugcb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ugcb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// generic single write port ram with registered read
module ugcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/uniform_grid_cell_binning_top.sv
`timescale 1ns / 1ps
`default_nettype none
// top level of the uniform grid cell binning block
//
// channel   dir   word contents
// -------   ---   ---------------------------------------------
// item      in    op, particle_id, pos_x, pos_y, pos_z
// result    out   status, cell_x, cell_y, cell_z, cell_index, slot
// cfg       in    index (0 cells_x, 1 cells_y, 2 cells_z), data
//
// one word per cycle unless result stalls; stages 1 and 2 feed the output register
// the rate is set by the count memory read-modify-write, closed by a one-entry forward
// reset clears the per-row valid bits at once, so there is no clearing pass
// a clear drops all row valid bits at once; the slot lists are never cleared
// a stalled result holds the output register; earlier stages keep filling behind it
module uniform_grid_cell_binning_top import ugcb_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	ugcb_in_if.sink    item,
	ugcb_out_if.source result,
	ugcb_cfg_if.sink   cfg
);

	// configuration registers
	logic [CFG_W-1:0] cells_x_q;
	logic [CFG_W-1:0] cells_y_q;
	logic [CFG_W-1:0] cells_z_q;

	// stage 1: raw word
	logic                    v_s1;
	logic                    op_s1;
	logic [ID_W-1:0]         id_s1;
	logic signed [POS_W-1:0] px_s1;
	logic signed [POS_W-1:0] py_s1;
	logic signed [POS_W-1:0] pz_s1;

	// stage 1 decode
	logic              ok_c;
	logic [AXIS_W-1:0] cx_c;
	logic [AXIS_W-1:0] cy_c;
	logic [AXIS_W-1:0] cz_c;
	logic [IDX_W-1:0]  idx_c;

	// stage 2: decoded word, count row read in flight
	logic              v_s2;
	logic              op_s2;
	logic [ID_W-1:0]   id_s2;
	logic              ok_s2;
	logic [AXIS_W-1:0] cx_s2;
	logic [AXIS_W-1:0] cy_s2;
	logic [AXIS_W-1:0] cz_s2;
	logic [IDX_W-1:0]  idx_s2;

	// count memory and valid bits
	logic [NUM_ROWS-1:0] vld_q;
	logic                fwd_vld_q;
	logic [ROW_AW-1:0]   fwd_row_q;
	logic [ROW_DW-1:0]   fwd_data_q;
	logic [ROW_AW-1:0]   row_s2;
	logic                half_s2;
	logic [ROW_AW-1:0]   cnt_rd_addr;
	logic [ROW_DW-1:0]   cnt_rd_data;
	logic [ROW_DW-1:0]   row_data;
	logic [ROW_DW-1:0]   row_new;
	logic                fwd_hit;
	logic [CNT_W-1:0]    cnt;
	logic                full;
	logic                ins_wr;
	status_t             status_c;

	// stage handshakes
	logic adv1;
	logic adv2;
	logic s2_free;

	// output register
	logic              out_valid_q;
	status_t           status_q;
	logic [AXIS_W-1:0] cell_x_q;
	logic [AXIS_W-1:0] cell_y_q;
	logic [AXIS_W-1:0] cell_z_q;
	logic [IDX_W-1:0]  cell_index_q;
	logic [SLOT_W-1:0] slot_q;

	// in range: non-negative and integer part below the clamped cell count
	function automatic logic axis_ok(input logic signed [POS_W-1:0] p,
		input logic [CFG_W-1:0] cells);
		logic [IP_W-1:0]  ip;
		logic [CFG_W-1:0] eff;
		ip  = p[POS_W-2:FRAC_BITS];
		eff = (cells > CFG_W'(MAX_CELLS_PER_AXIS)) ? CFG_W'(MAX_CELLS_PER_AXIS) : cells;
		return !p[POS_W-1] && (ip < IP_W'(eff));
	endfunction

	// ---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= CELLS_RESET;
			cells_y_q <= CELLS_RESET;
			cells_z_q <= CELLS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CELLS_X: cells_x_q <= cfg.data;
				REG_CELLS_Y: cells_y_q <= cfg.data;
				REG_CELLS_Z: cells_z_q <= cfg.data;
				default: ; // index beyond the register list is dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- flow
	assign adv2       = v_s2 && (!out_valid_q || result.ready);
	assign s2_free    = !v_s2 || adv2;
	assign adv1       = v_s1 && s2_free;
	assign item.ready = !v_s1 || adv1;

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1 <= item.op;
			id_s1 <= item.particle_id;
			px_s1 <= item.pos_x;
			py_s1 <= item.pos_y;
			pz_s1 <= item.pos_z;
		end
	end

	// cell is the truncated integer part on each axis
	always_comb begin
		ok_c  = axis_ok(px_s1, cells_x_q) && axis_ok(py_s1, cells_y_q)
			&& axis_ok(pz_s1, cells_z_q);
		cx_c  = px_s1[FRAC_BITS +: AXIS_W];
		cy_c  = py_s1[FRAC_BITS +: AXIS_W];
		cz_c  = pz_s1[FRAC_BITS +: AXIS_W];
		idx_c = {cx_c, cy_c, cz_c};
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= adv1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s2  <= op_s1;
			id_s2  <= id_s1;
			ok_s2  <= ok_c;
			cx_s2  <= cx_c;
			cy_s2  <= cy_c;
			cz_s2  <= cz_c;
			idx_s2 <= idx_c;
		end
	end

	assign row_s2  = idx_s2[IDX_W-1:1];
	assign half_s2 = idx_s2[0];

	// reread the held row while stage 2 waits, so its read data stays current
	assign cnt_rd_addr = adv1 ? idx_c[IDX_W-1:1] : row_s2;

	ugcb_ram #(
		.WIDTH (ROW_DW),
		.DEPTH (NUM_ROWS)
	) u_count_ram (
		.clk     (clk),
		.wr_en   (ins_wr),
		.wr_addr (row_s2),
		.wr_data (row_new),
		.rd_addr (cnt_rd_addr),
		.rd_data (cnt_rd_data)
	);

	// forward covers the write made in the same cycle as the read
	always_comb begin
		fwd_hit  = fwd_vld_q && (fwd_row_q == row_s2);
		row_data = fwd_hit ? fwd_data_q : (vld_q[row_s2] ? cnt_rd_data : '0);
		cnt      = half_s2 ? row_data[CNT_W +: CNT_W] : row_data[0 +: CNT_W];
		full     = cnt >= CNT_W'(SLOTS_PER_CELL);
		row_new  = row_data;
		if (half_s2) begin
			row_new[CNT_W +: CNT_W] = cnt + CNT_W'(1);
		end else begin
			row_new[0 +: CNT_W] = cnt + CNT_W'(1);
		end
		priority if (op_s2 == OP_CLEAR) begin
			status_c = ST_CLEARED;
		end else if (!ok_s2) begin
			status_c = ST_OUT_OF_DOMAIN;
		end else if (full) begin
			status_c = ST_CELL_FULL;
		end else begin
			status_c = ST_STORED;
		end
		ins_wr = adv2 && (status_c == ST_STORED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
		end else if (adv2) begin
			if (status_c == ST_CLEARED) begin
				vld_q     <= '0;
				fwd_vld_q <= 1'b0;
			end else if (ins_wr) begin
				vld_q[row_s2] <= 1'b1;
				fwd_vld_q     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_wr) begin
			fwd_row_q  <= row_s2;
			fwd_data_q <= row_new;
		end
	end

	// slot lists are written only
	ugcb_ram #(
		.WIDTH (ID_W),
		.DEPTH (SLOT_DEPTH)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ins_wr),
		.wr_addr ({idx_s2, cnt[SLOT_W-1:0]}),
		.wr_data (id_s2),
		.rd_addr ({idx_s2, cnt[SLOT_W-1:0]}),
		.rd_data ()
	);

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// cell fields are zero unless the id was stored
	always_ff @(posedge clk) begin
		if (adv2) begin
			status_q     <= status_c;
			cell_x_q     <= (status_c == ST_STORED) ? cx_s2 : '0;
			cell_y_q     <= (status_c == ST_STORED) ? cy_s2 : '0;
			cell_z_q     <= (status_c == ST_STORED) ? cz_s2 : '0;
			cell_index_q <= (status_c == ST_STORED) ? idx_s2 : '0;
			slot_q       <= (status_c == ST_STORED) ? cnt[SLOT_W-1:0] : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = status_q;
	assign result.cell_x     = cell_x_q;
	assign result.cell_y     = cell_y_q;
	assign result.cell_z     = cell_z_q;
	assign result.cell_index = cell_index_q;
	assign result.slot       = slot_q;

	// ---------------------------------------------------------------- checks
	// a stored count leaves its row valid
	assert property (@(posedge clk) disable iff (!arst_n)
		ins_wr |=> vld_q[$past(row_s2)])
		else $error("row not valid after count write");

	// a clear empties every row
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && status_c == ST_CLEARED) |=> (vld_q == '0 && !fwd_vld_q))
		else $error("rows still valid after clear");

	// the forward entry only ever names a valid row
	assert property (@(posedge clk) disable iff (!arst_n)
		fwd_vld_q |-> vld_q[fwd_row_q])
		else $error("forward entry on an invalid row");

	// a stored result reports the index of its own coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_STORED)
			|-> (cell_index_q == {cell_x_q, cell_y_q, cell_z_q}))
		else $error("cell index does not match coordinates");

endmodule
`default_nettype wire
